@@ rtl/core/stc_pkg.sv @@
// shared types and constants of the system timer with compare channels
package stc_pkg;

	localparam int MaxChannels = 4;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} stc_op_t;

	localparam logic [13:0] OFF_CONTROL = 14'h0000;
	localparam logic [13:0] OFF_COUNTER = 14'h0004;
	localparam logic [3:0]  SUB_CTRL    = 4'h0;
	localparam logic [3:0]  SUB_IRQ     = 4'h4;
	localparam logic [3:0]  SUB_COMPARE = 4'h8;
	localparam logic [9:0]  CH_BLOCK_LO = 10'd1;
	localparam logic [9:0]  CH_BLOCK_HI = 10'd4;

	localparam logic [15:0] CTRL_MASK = 16'hff03;
	localparam int          CTRL_EN   = 0;

	typedef struct packed {
		logic [1:0]  operation;
		logic [13:0] reg_offset;
		logic [31:0] write_data;
	} stc_in_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [3:0]  irq_lines;
	} stc_out_t;

endpackage

@@ rtl/core/stc_core.sv @@
// timer register file, prescaler, counter and compare channels
module stc_core #(
	parameter int NUM_CHANNELS = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  stc_pkg::stc_in_t item,
	output stc_pkg::stc_out_t result
);
	import stc_pkg::*;

	logic [15:0] ctrl_q, ctrl_d;
	logic [31:0] count_q, count_d;
	logic [7:0]  presc_cnt_q, presc_cnt_d;
	logic [NUM_CHANNELS-1:0] en_q, en_d, flag_q, flag_d;
	logic [31:0] cmp_q [NUM_CHANNELS];
	logic [31:0] cmp_d [NUM_CHANNELS];

	logic [9:0]  blk;
	logic [9:0]  ch_full;
	logic [1:0]  ch_idx;
	logic [3:0]  sub;
	logic        ch_hit;
	logic [31:0] rd;
	logic [3:0]  irq;

	always_comb begin
		blk     = item.reg_offset[13:4];
		sub     = item.reg_offset[3:0];
		ch_full = blk - CH_BLOCK_LO;
		ch_idx  = ch_full[1:0];
		ch_hit  = (blk >= CH_BLOCK_LO) && (blk <= CH_BLOCK_HI)
			&& ({8'd0, ch_idx} < 10'(NUM_CHANNELS))
			&& (sub == SUB_CTRL || sub == SUB_IRQ || sub == SUB_COMPARE);
	end

	always_comb begin
		ctrl_d      = ctrl_q;
		count_d     = count_q;
		presc_cnt_d = presc_cnt_q;
		en_d        = en_q;
		flag_d      = flag_q;
		for (int n = 0; n < NUM_CHANNELS; n++) begin
			cmp_d[n] = cmp_q[n];
		end
		rd = '0;
		case (stc_op_t'(item.operation))
			OP_TICK: begin
				if (ctrl_q[CTRL_EN]) begin
					if (presc_cnt_q >= ctrl_q[15:8]) begin
						presc_cnt_d = '0;
						count_d     = count_q + 32'd1;
						for (int n = 0; n < NUM_CHANNELS; n++) begin
							if (en_q[n] && cmp_q[n] == count_d) begin
								flag_d[n] = 1'b1;
							end
						end
					end else begin
						presc_cnt_d = presc_cnt_q + 8'd1;
					end
				end
			end
			OP_READ: begin
				if (item.reg_offset == OFF_CONTROL) begin
					rd = {16'd0, ctrl_q};
				end else if (item.reg_offset == OFF_COUNTER) begin
					rd = count_q;
				end else if (ch_hit) begin
					for (int n = 0; n < NUM_CHANNELS; n++) begin
						if (ch_idx == 2'(n)) begin
							case (sub)
								SUB_CTRL:    rd = {31'd0, en_q[n]};
								SUB_IRQ:     rd = {31'd0, flag_q[n]};
								default:     rd = cmp_q[n];
							endcase
						end
					end
				end
			end
			OP_WRITE: begin
				if (item.reg_offset == OFF_CONTROL) begin
					ctrl_d = item.write_data[15:0] & CTRL_MASK;
				end else if (item.reg_offset == OFF_COUNTER) begin
					count_d = item.write_data;
				end else if (ch_hit) begin
					for (int n = 0; n < NUM_CHANNELS; n++) begin
						if (ch_idx == 2'(n)) begin
							case (sub)
								SUB_CTRL: en_d[n] = item.write_data[0];
								SUB_IRQ: begin
									if (item.write_data[0]) begin
										flag_d[n] = 1'b0;
									end
								end
								default: cmp_d[n] = item.write_data;
							endcase
						end
					end
				end
			end
			default: begin
				rd = '0;
			end
		endcase
		irq = '0;
		for (int n = 0; n < NUM_CHANNELS; n++) begin
			irq[n] = flag_d[n] & en_d[n];
		end
		result.read_data = rd;
		result.irq_lines = irq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q      <= '0;
			count_q     <= '0;
			presc_cnt_q <= '0;
			en_q        <= '0;
			flag_q      <= '0;
			for (int n = 0; n < NUM_CHANNELS; n++) begin
				cmp_q[n] <= '0;
			end
		end else if (advance) begin
			ctrl_q      <= ctrl_d;
			count_q     <= count_d;
			presc_cnt_q <= presc_cnt_d;
			en_q        <= en_d;
			flag_q      <= flag_d;
			for (int n = 0; n < NUM_CHANNELS; n++) begin
				cmp_q[n] <= cmp_d[n];
			end
		end
	end

endmodule

@@ rtl/core/system_timer_compare_channels.sv @@
// system timer with compare channels: top level with input and result registers
//
// Each word is a base-clock tick, a bus read or a bus write, and gives exactly one
// result word: the read data (zero for anything but a mapped read) and the
// interrupt lines as they stand after the word. A word is taken into an input
// register, worked on by the register file, prescaler and compare logic, and
// lands in a result register, so one word per cycle is sustained while
// out_ready stays high. in_ready drops only while the result register is
// full and not being taken. Channels at or beyond NUM_CHANNELS read as zero and
// ignore writes; their interrupt lines stay low.
module system_timer_compare_channels #(
	parameter int NUM_CHANNELS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  stc_pkg::stc_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output stc_pkg::stc_out_t out_data
);
	import stc_pkg::*;

	logic     valid_s1;
	stc_in_t  item_s1;
	logic     advance;
	stc_out_t result;
	stc_out_t out_q;
	logic     out_valid_q;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	stc_core #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

endmodule
